// ===== src/cpustep_pkg.sv =====
// ----------------------------------------------------------------------------
// cpustep_pkg
// Shared types, opcodes, status codes and helpers of the 16-bit CPU step core.
// ----------------------------------------------------------------------------
package cpustep_pkg;

  localparam int MEM_WORDS_DEF = 256;
  localparam int NUM_REGS      = 4;
  localparam int FRAME_WORDS   = NUM_REGS + 2;
  localparam int STACK_TOP     = 256;

  localparam logic [4:0] OP_LD    = 5'd0;
  localparam logic [4:0] OP_ST    = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_ADDC  = 5'd3;
  localparam logic [4:0] OP_SUB   = 5'd4;
  localparam logic [4:0] OP_SUBC  = 5'd5;
  localparam logic [4:0] OP_AND   = 5'd6;
  localparam logic [4:0] OP_XOR   = 5'd7;
  localparam logic [4:0] OP_COMPL = 5'd8;
  localparam logic [4:0] OP_SHL   = 5'd9;
  localparam logic [4:0] OP_SHLA  = 5'd10;
  localparam logic [4:0] OP_SHR   = 5'd11;
  localparam logic [4:0] OP_SHRA  = 5'd12;
  localparam logic [4:0] OP_COMP  = 5'd13;
  localparam logic [4:0] OP_GETST = 5'd14;
  localparam logic [4:0] OP_PUTST = 5'd15;
  localparam logic [4:0] OP_JUMP  = 5'd16;
  localparam logic [4:0] OP_JUMPL = 5'd17;
  localparam logic [4:0] OP_JUMPE = 5'd18;
  localparam logic [4:0] OP_JUMPG = 5'd19;
  localparam logic [4:0] OP_CALL  = 5'd20;
  localparam logic [4:0] OP_RET   = 5'd21;
  localparam logic [4:0] OP_READ  = 5'd22;
  localparam logic [4:0] OP_WRITE = 5'd23;
  localparam logic [4:0] OP_HALT  = 5'd24;
  localparam logic [4:0] OP_NOOP  = 5'd25;

  localparam logic [1:0] REQ_MEM_WR = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_EXEC   = 2'd2;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_FLOOR = 2'd2;
  localparam logic [1:0] REG_SLICE = 2'd3;

  localparam logic [15:0] F_C = 16'h0001;
  localparam logic [15:0] F_G = 16'h0002;
  localparam logic [15:0] F_E = 16'h0004;
  localparam logic [15:0] F_L = 16'h0008;
  localparam logic [15:0] F_V = 16'h0010;

  localparam logic [7:0] RET_SLICE = 8'h00;
  localparam logic [7:0] RET_HALT  = 8'h20;
  localparam logic [7:0] RET_OOB   = 8'h40;
  localparam logic [7:0] RET_OVER  = 8'h60;
  localparam logic [7:0] RET_UNDER = 8'h80;
  localparam logic [7:0] RET_BAD   = 8'ha0;
  localparam logic [7:0] RET_READ  = 8'hc0;
  localparam logic [7:0] RET_WRITE = 8'he0;

  typedef enum logic [3:0] {
    ST_RUN   = 4'd0,
    ST_SLICE = 4'd1,
    ST_HALT  = 4'd2,
    ST_OOB   = 4'd3,
    ST_OVER  = 4'd4,
    ST_UNDER = 4'd5,
    ST_BAD   = 4'd6,
    ST_READ  = 4'd7,
    ST_WRITE = 4'd8
  } step_st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_FETCH,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_LOAD,
    S_PUSH,
    S_POP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        wr;
    logic [15:0] val;
    logic [15:0] sr;
  } alu_res_t;

  function automatic logic [15:0] set_ret(logic [15:0] s, logic [7:0] code);
    return (s & 16'hff1f) | {8'h00, code};
  endfunction

  function automatic logic [15:0] set_io(logic [15:0] s, logic [7:0] code,
                                         logic [1:0] rd);
    return (s & 16'hf01f) | {6'h00, rd, code};
  endfunction

endpackage

// ===== src/cpustep_ifs.sv =====
// ----------------------------------------------------------------------------
// cpustep channel interfaces
// Valid/ready channels carrying step requests and step results.
// ----------------------------------------------------------------------------
interface cpustep_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         mem_addr;
  logic [15:0]        mem_data;
  logic [8:0]         start_pc;
  logic [8:0]         start_sp;
  logic signed [15:0] read_value;

  modport source (output valid, req_type, mem_addr, mem_data, start_pc, start_sp,
                  read_value, input ready);
  modport sink   (input valid, req_type, mem_addr, mem_data, start_pc, start_sp,
                  read_value, output ready);
endinterface

interface cpustep_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         step_status;
  logic signed [15:0] out_value;
  logic [1:0]         io_register;
  logic [8:0]         pc_now;
  logic [15:0]        status_word;
  logic [31:0]        clock_now;

  modport source (output valid, step_status, out_value, io_register, pc_now,
                  status_word, clock_now, input ready);
  modport sink   (input valid, step_status, out_value, io_register, pc_now,
                  status_word, clock_now, output ready);
endinterface

// ===== src/cpustep_ram.sv =====
// ----------------------------------------------------------------------------
// cpustep_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpustep_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cpustep_alu.sv =====
// ----------------------------------------------------------------------------
// cpustep_alu
// Arithmetic, logic, shift, compare and status-move instructions.
// ----------------------------------------------------------------------------
module cpustep_alu (
  input  logic [4:0]             op,
  input  logic [15:0]            a,
  input  logic [15:0]            b,
  input  logic [15:0]            sr,
  output cpustep_pkg::alu_res_t  res
);

  logic [16:0] sum;
  logic [16:0] sub_t;
  logic [15:0] diff;
  logic        cin;

  assign cin   = sr[0];
  assign sum   = {1'b0, a} + {1'b0, b} + {16'h0000, (op == cpustep_pkg::OP_ADDC) & cin};
  assign sub_t = {1'b0, b} + {16'h0000, (op == cpustep_pkg::OP_SUBC) & cin};
  assign diff  = a - sub_t[15:0];

  always_comb begin
    res.wr  = 1'b1;
    res.val = a;
    res.sr  = sr;
    unique case (op)
      cpustep_pkg::OP_ADD, cpustep_pkg::OP_ADDC: begin
        res.val   = sum[15:0];
        res.sr[0] = sum[16];
        if (op == cpustep_pkg::OP_ADD) begin
          res.sr[4] = ((a ^ sum[15:0]) & (b ^ sum[15:0]) & 16'h8000) != 16'h0000;
        end
      end
      cpustep_pkg::OP_SUB, cpustep_pkg::OP_SUBC: begin
        res.val   = diff;
        res.sr[0] = {1'b0, a} < sub_t;
        if (op == cpustep_pkg::OP_SUB) begin
          res.sr[4] = ((a ^ b) & ~(b ^ diff) & 16'h8000) != 16'h0000;
        end
      end
      cpustep_pkg::OP_AND:   res.val = a & b;
      cpustep_pkg::OP_XOR:   res.val = a ^ b;
      cpustep_pkg::OP_COMPL: res.val = ~a;
      cpustep_pkg::OP_SHL: begin
        res.sr[0] = a[15];
        res.val   = {a[14:0], 1'b0};
      end
      cpustep_pkg::OP_SHLA: begin
        res.sr[0] = a[15];
        res.val   = {a[15], a[13:0], 1'b0};
      end
      cpustep_pkg::OP_SHR: begin
        res.sr[0] = a[0];
        res.val   = {1'b0, a[15:1]};
      end
      cpustep_pkg::OP_SHRA: begin
        res.sr[0] = a[0];
        res.val   = {a[15], a[15:1]};
      end
      cpustep_pkg::OP_COMP: begin
        res.wr = 1'b0;
        res.sr = sr & 16'hffe1;
        if ($signed(a) < $signed(b)) begin
          res.sr = res.sr | cpustep_pkg::F_L;
        end else if (a == b) begin
          res.sr = res.sr | cpustep_pkg::F_E;
        end else begin
          res.sr = res.sr | cpustep_pkg::F_G;
        end
      end
      cpustep_pkg::OP_GETST: res.val = sr;
      cpustep_pkg::OP_PUTST: begin
        res.wr = 1'b0;
        res.sr = a;
      end
      default: res.wr = 1'b0;
    endcase
  end

endmodule

// ===== src/sixteen_bit_four_register_cpu_step_core.sv =====
// ----------------------------------------------------------------------------
// sixteen_bit_four_register_cpu_step_core
// Sixteen-bit four-register machine stepped one instruction per transaction.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (valid/ready). A memory-write or slice-start
// transaction returns nothing and leaves the core idle. An execute
// transaction runs at most one instruction and returns one result on
// out_ch. The user must write the configuration registers over the APB
// port (base, limit, floor, slice at byte offsets 0, 4, 8, 12) only while
// the core is idle; the core itself does not enforce this.
// An execute transaction goes from idle to a pre-check state and from there
// straight to done when the slice is already over or pc is at or past base
// plus limit; otherwise through fetch, two register-file reads and exec,
// then a load state for a load from memory or push or pop states for a call
// or a return (the single word-memory port moves one frame word per cycle).
// One transaction is in flight at a time; in_ch.ready is high while idle.
// A result waits in the output register; the next request is accepted
// meanwhile and stalls only at its own result while out_ch.ready is low.
// Reset clears registers, pc, status and clock and sets sp to 256; word
// memory is undefined until written.
// ----------------------------------------------------------------------------
module sixteen_bit_four_register_cpu_step_core #(
  parameter int MEM_WORDS = cpustep_pkg::MEM_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cpustep_in_if.sink           in_ch,
  cpustep_out_if.source        out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW = $clog2(MEM_WORDS);

  function automatic logic [AW-1:0] widx(logic [9:0] v);
    logic [AW+9:0] e;
    e = {{AW{1'b0}}, v};
    return e[AW-1:0];
  endfunction

  cpustep_pkg::state_t   state_r, state_nxt;
  cpustep_pkg::step_st_t st_r, st_nxt, fin_st;

  logic [7:0]  base_r;
  logic [8:0]  limit_r, floor_r;
  logic [31:0] slice_r;

  logic [15:0] ir_r, ir_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [9:0]  pc_r, pc_nxt;
  logic [8:0]  sp_r, sp_nxt;
  logic [15:0] sr_r, sr_nxt, fin_sr;
  logic [31:0] tick_r, tick_nxt, dl_r, dl_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        chk_r, chk_nxt;
  logic [15:0] io_out_r, io_out_nxt;
  logic [1:0]  io_reg_r, io_reg_nxt;
  logic [15:0] rv_r;

  logic        ov_r;
  logic [3:0]  o_st_r;
  logic [15:0] o_val_r, o_sr_r;
  logic [1:0]  o_reg_r;
  logic [8:0]  o_pc_r;
  logic [31:0] o_clk_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;

  logic        rf_we;
  logic [1:0]  rf_waddr, rf_raddr;
  logic [15:0] rf_wdata, rf_rdata, rf_q;
  logic [3:0]  rf_vld_r;
  logic        rf_rvld_r;

  logic        accept, cfg_wr, out_free;
  logic [4:0]  op;
  logic [1:0]  rd, rs;
  logic        imm;
  logic [7:0]  addr;
  logic [15:0] k;
  logic [9:0]  tgt;
  logic        oob, sp_low, sp_high, stop_now;

  cpustep_pkg::alu_res_t alu;

  cpustep_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cpustep_ram #(.WIDTH(16), .DEPTH(cpustep_pkg::NUM_REGS)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  cpustep_alu u_alu (
    .op  (op),
    .a   (a_r),
    .b   (b_r),
    .sr  (sr_r),
    .res (alu)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !ov_r || out_ch.ready;
  assign pready   = 1'b1;

  assign op   = ir_r[15:11];
  assign rd   = ir_r[10:9];
  assign imm  = ir_r[8];
  assign rs   = ir_r[7:6];
  assign addr = ir_r[7:0];
  assign k    = {{8{addr[7]}}, addr};
  assign tgt  = {2'b00, addr} + {2'b00, base_r};
  assign oob  = {1'b0, addr} >= limit_r;
  assign sp_low  = {1'b0, sp_r} < ({1'b0, floor_r} + 10'(cpustep_pkg::FRAME_WORDS));
  assign sp_high = sp_r > 9'(cpustep_pkg::STACK_TOP - cpustep_pkg::FRAME_WORDS);
  assign rf_q = rf_rvld_r ? rf_rdata : 16'h0000;

  assign stop_now = (pc_r >= ({2'b00, base_r} + {1'b0, limit_r})) || (tick_r >= dl_r);

  always_comb begin
    unique case (paddr[3:2])
      cpustep_pkg::REG_BASE:  prdata = {24'h0, base_r};
      cpustep_pkg::REG_LIMIT: prdata = {23'h0, limit_r};
      cpustep_pkg::REG_FLOOR: prdata = {23'h0, floor_r};
      cpustep_pkg::REG_SLICE: prdata = slice_r;
      default:                prdata = 32'h0;
    endcase
  end

  always_comb begin
    fin_sr = sr_r;
    fin_st = st_r;
    if (chk_r) begin
      if (pc_r >= ({2'b00, base_r} + {1'b0, limit_r})) begin
        fin_sr = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_OOB);
        fin_st = cpustep_pkg::ST_OOB;
      end else if (tick_r >= dl_r) begin
        fin_sr = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_SLICE);
        fin_st = cpustep_pkg::ST_SLICE;
      end else begin
        fin_st = cpustep_pkg::ST_RUN;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpustep_pkg::S_IDLE:
        if (accept && in_ch.req_type == cpustep_pkg::REQ_EXEC) begin
          state_nxt = cpustep_pkg::S_PRE;
        end
      cpustep_pkg::S_PRE:   state_nxt = stop_now ? cpustep_pkg::S_DONE : cpustep_pkg::S_FETCH;
      cpustep_pkg::S_FETCH: state_nxt = cpustep_pkg::S_RDA;
      cpustep_pkg::S_RDA:   state_nxt = cpustep_pkg::S_RDB;
      cpustep_pkg::S_RDB:   state_nxt = cpustep_pkg::S_EXEC;
      cpustep_pkg::S_EXEC: begin
        state_nxt = cpustep_pkg::S_DONE;
        if (op == cpustep_pkg::OP_LD && !imm && !oob) begin
          state_nxt = cpustep_pkg::S_LOAD;
        end else if (op == cpustep_pkg::OP_CALL && !oob && !sp_low) begin
          state_nxt = cpustep_pkg::S_PUSH;
        end else if (op == cpustep_pkg::OP_RET && !sp_high) begin
          state_nxt = cpustep_pkg::S_POP;
        end
      end
      cpustep_pkg::S_LOAD:  state_nxt = cpustep_pkg::S_DONE;
      cpustep_pkg::S_PUSH:  if (cnt_r == 3'd4) state_nxt = cpustep_pkg::S_DONE;
      cpustep_pkg::S_POP:   if (cnt_r == 3'd5) state_nxt = cpustep_pkg::S_DONE;
      cpustep_pkg::S_DONE:  if (out_free) state_nxt = cpustep_pkg::S_IDLE;
      default:              state_nxt = cpustep_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ir_nxt     = ir_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    pc_nxt     = pc_r;
    sp_nxt     = sp_r;
    sr_nxt     = sr_r;
    tick_nxt   = tick_r;
    dl_nxt     = dl_r;
    cnt_nxt    = cnt_r;
    chk_nxt    = chk_r;
    st_nxt     = st_r;
    io_out_nxt = io_out_r;
    io_reg_nxt = io_reg_r;
    mem_we     = 1'b0;
    mem_waddr  = widx(pc_r);
    mem_wdata  = a_r;
    mem_raddr  = widx(pc_r);
    rf_we      = 1'b0;
    rf_waddr   = rd;
    rf_wdata   = alu.val;
    rf_raddr   = rd;

    unique case (state_r)
      cpustep_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_ch.req_type)
            cpustep_pkg::REQ_MEM_WR: begin
              mem_we    = 1'b1;
              mem_waddr = widx({2'b00, in_ch.mem_addr});
              mem_wdata = in_ch.mem_data;
            end
            cpustep_pkg::REQ_START: begin
              pc_nxt = {1'b0, in_ch.start_pc};
              sp_nxt = in_ch.start_sp;
              dl_nxt = tick_r + slice_r;
            end
            cpustep_pkg::REQ_EXEC: begin
              io_out_nxt = 16'h0000;
              io_reg_nxt = 2'b00;
              chk_nxt    = 1'b1;
            end
            default: ;
          endcase
        end
      end
      cpustep_pkg::S_PRE: mem_raddr = widx(pc_r);
      cpustep_pkg::S_FETCH: begin
        ir_nxt   = mem_rdata;
        pc_nxt   = {1'b0, pc_r[8:0] + 9'd1};
        tick_nxt = tick_r + 32'd1;
        rf_raddr = mem_rdata[10:9];
      end
      cpustep_pkg::S_RDA: begin
        a_nxt    = rf_q;
        rf_raddr = rs;
      end
      cpustep_pkg::S_RDB: b_nxt = imm ? k : rf_q;
      cpustep_pkg::S_EXEC: begin
        chk_nxt = 1'b1;
        priority if (op == cpustep_pkg::OP_LD) begin
          if (imm) begin
            rf_we    = 1'b1;
            rf_wdata = k;
          end else if (oob) begin
            sr_nxt  = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_OOB);
            st_nxt  = cpustep_pkg::ST_OOB;
            chk_nxt = 1'b0;
          end else begin
            mem_raddr = widx(tgt);
          end
        end else if (op == cpustep_pkg::OP_ST) begin
          if (oob) begin
            sr_nxt  = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_OOB);
            st_nxt  = cpustep_pkg::ST_OOB;
            chk_nxt = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = widx(tgt);
            mem_wdata = a_r;
            tick_nxt  = tick_r + 32'd3;
          end
        end else if (op <= cpustep_pkg::OP_PUTST) begin
          rf_we    = alu.wr;
          rf_wdata = alu.val;
          sr_nxt   = alu.sr;
        end else if (op <= cpustep_pkg::OP_JUMPG) begin
          if (op == cpustep_pkg::OP_JUMP
              || (op == cpustep_pkg::OP_JUMPL && sr_r[3])
              || (op == cpustep_pkg::OP_JUMPE && sr_r[2])
              || (op == cpustep_pkg::OP_JUMPG && sr_r[1])) begin
            pc_nxt = tgt;
          end
          if (oob) begin
            sr_nxt  = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_OOB);
            st_nxt  = cpustep_pkg::ST_OOB;
            chk_nxt = 1'b0;
          end
        end else if (op == cpustep_pkg::OP_CALL) begin
          if (oob) begin
            sr_nxt  = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_OOB);
            st_nxt  = cpustep_pkg::ST_OOB;
            chk_nxt = 1'b0;
          end else if (sp_low) begin
            sr_nxt  = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_OVER);
            st_nxt  = cpustep_pkg::ST_OVER;
            chk_nxt = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = widx({1'b0, sp_r - 9'd1});
            mem_wdata = {6'h00, pc_r};
            sp_nxt    = sp_r - 9'd1;
            rf_raddr  = 2'd0;
            cnt_nxt   = 3'd0;
          end
        end else if (op == cpustep_pkg::OP_RET) begin
          if (sp_high) begin
            sr_nxt  = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_UNDER);
            st_nxt  = cpustep_pkg::ST_UNDER;
            chk_nxt = 1'b0;
          end else begin
            mem_raddr = widx({1'b0, sp_r});
            sp_nxt    = sp_r + 9'd1;
            cnt_nxt   = 3'd0;
          end
        end else if (op == cpustep_pkg::OP_READ) begin
          rf_we      = 1'b1;
          rf_wdata   = rv_r;
          sr_nxt     = cpustep_pkg::set_io(sr_r, cpustep_pkg::RET_READ, rd);
          io_reg_nxt = rd;
          st_nxt     = cpustep_pkg::ST_READ;
          chk_nxt    = 1'b0;
        end else if (op == cpustep_pkg::OP_WRITE) begin
          io_out_nxt = a_r;
          sr_nxt     = cpustep_pkg::set_io(sr_r, cpustep_pkg::RET_WRITE, rd);
          io_reg_nxt = rd;
          st_nxt     = cpustep_pkg::ST_WRITE;
          chk_nxt    = 1'b0;
        end else if (op == cpustep_pkg::OP_HALT) begin
          sr_nxt  = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_HALT);
          st_nxt  = cpustep_pkg::ST_HALT;
          chk_nxt = 1'b0;
        end else if (op == cpustep_pkg::OP_NOOP) begin
          chk_nxt = 1'b1;
        end else begin
          sr_nxt  = cpustep_pkg::set_ret(sr_r, cpustep_pkg::RET_BAD);
          st_nxt  = cpustep_pkg::ST_BAD;
          chk_nxt = 1'b0;
        end
      end
      cpustep_pkg::S_LOAD: begin
        rf_we    = 1'b1;
        rf_wdata = mem_rdata;
        tick_nxt = tick_r + 32'd3;
      end
      cpustep_pkg::S_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = widx({1'b0, sp_r - 9'd1});
        sp_nxt    = sp_r - 9'd1;
        cnt_nxt   = cnt_r + 3'd1;
        rf_raddr  = cnt_nxt[1:0];
        if (cnt_r == 3'd4) begin
          mem_wdata = sr_r;
          pc_nxt    = tgt;
          tick_nxt  = tick_r + 32'd3;
        end else begin
          mem_wdata = rf_q;
        end
      end
      cpustep_pkg::S_POP: begin
        cnt_nxt   = cnt_r + 3'd1;
        mem_raddr = widx({1'b0, sp_r});
        if (cnt_r == 3'd0) begin
          sr_nxt = mem_rdata;
          sp_nxt = sp_r + 9'd1;
        end else if (cnt_r == 3'd5) begin
          pc_nxt   = {1'b0, mem_rdata[8:0]};
          tick_nxt = tick_r + 32'd3;
        end else begin
          rf_we    = 1'b1;
          rf_waddr = 2'(3'd4 - cnt_r);
          rf_wdata = mem_rdata;
          sp_nxt   = sp_r + 9'd1;
        end
      end
      cpustep_pkg::S_DONE: begin
        if (out_free) begin
          sr_nxt = fin_sr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cpustep_pkg::S_IDLE;
      base_r    <= 8'd0;
      limit_r   <= 9'd256;
      floor_r   <= 9'd0;
      slice_r   <= 32'd15;
      pc_r      <= 10'd0;
      sp_r      <= 9'(cpustep_pkg::STACK_TOP);
      sr_r      <= 16'h0000;
      tick_r    <= 32'd0;
      dl_r      <= 32'd0;
      cnt_r     <= 3'd0;
      chk_r     <= 1'b0;
      st_r      <= cpustep_pkg::ST_RUN;
      rf_vld_r  <= 4'h0;
      rf_rvld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= pc_nxt;
      sp_r      <= sp_nxt;
      sr_r      <= sr_nxt;
      tick_r    <= tick_nxt;
      dl_r      <= dl_nxt;
      cnt_r     <= cnt_nxt;
      chk_r     <= chk_nxt;
      st_r      <= st_nxt;
      rf_rvld_r <= rf_vld_r[rf_raddr];
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      if (cfg_wr) begin
        unique case (paddr[3:2])
          cpustep_pkg::REG_BASE:  base_r  <= pwdata[7:0];
          cpustep_pkg::REG_LIMIT: limit_r <= pwdata[8:0];
          cpustep_pkg::REG_FLOOR: floor_r <= pwdata[8:0];
          cpustep_pkg::REG_SLICE: slice_r <= pwdata;
          default: ;
        endcase
      end
      if (state_r == cpustep_pkg::S_DONE && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ir_r     <= ir_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    io_out_r <= io_out_nxt;
    io_reg_r <= io_reg_nxt;
    if (accept) begin
      rv_r <= in_ch.read_value;
    end
    if (state_r == cpustep_pkg::S_DONE && out_free) begin
      o_st_r  <= fin_st;
      o_val_r <= io_out_r;
      o_reg_r <= io_reg_r;
      o_pc_r  <= pc_r[8:0];
      o_sr_r  <= fin_sr;
      o_clk_r <= tick_r;
    end
  end

  assign in_ch.ready        = (state_r == cpustep_pkg::S_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.step_status = o_st_r;
  assign out_ch.out_value   = o_val_r;
  assign out_ch.io_register = o_reg_r;
  assign out_ch.pc_now      = o_pc_r;
  assign out_ch.status_word = o_sr_r;
  assign out_ch.clock_now   = o_clk_r;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the 16-bit CPU step core against an in-bench model of the machine:
// memory loads, slice starts and random programs under several settings,
// with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [1:0]         req_type;
    logic [7:0]         mem_addr;
    logic [15:0]        mem_data;
    logic [8:0]         start_pc;
    logic [8:0]         start_sp;
    logic signed [15:0] read_value;
  } step_req_t;

  typedef struct {
    logic [3:0]  step_status;
    logic [15:0] out_value;
    logic [1:0]  io_register;
    logic [8:0]  pc_now;
    logic [15:0] status_word;
    logic [31:0] clock_now;
  } step_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cpustep_in_if in_ch ();
  cpustep_out_if out_ch ();

  sixteen_bit_four_register_cpu_step_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // machine model
  logic [15:0] mem_img [256];
  logic [15:0] gpr [4];
  logic [8:0]  pc_m, sp_m;
  logic [15:0] sr_m;
  logic [31:0] ticks, deadline;
  logic [7:0]  base_m;
  logic [8:0]  limit_m, floor_m;
  logic [31:0] slice_m;

  step_req_t pending_reqs[$];
  step_res_t expected_steps[$];
  int failures = 0;
  bit took = 0;
  int idle_cycles = 0;

  task automatic exit_chk(output cpustep_pkg::step_st_t st);
    st = cpustep_pkg::ST_RUN;
    if (int'(pc_m) >= int'(base_m) + int'(limit_m)) begin
      sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_OOB);
      st = cpustep_pkg::ST_OOB;
    end else if (ticks >= deadline) begin
      sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_SLICE);
      st = cpustep_pkg::ST_SLICE;
    end
  endtask

  task automatic execute_insn(input logic [15:0] rdval, output cpustep_pkg::step_st_t st,
                              output logic [15:0] oval, output logic [1:0] ioreg);
    logic [15:0] ir, a, b, k, res, cin;
    logic [4:0] op;
    logic [1:0] rd, rs;
    logic [7:0] adr;
    logic imm, cond, done;
    logic [16:0] t;
    oval = '0;
    ioreg = '0;
    done = 1'b0;
    exit_chk(st);
    if (st == cpustep_pkg::ST_RUN) begin
      ir = mem_img[pc_m[7:0]];
      pc_m = pc_m + 9'd1;
      ticks = ticks + 32'd1;
      op = ir[15:11];
      rd = ir[10:9];
      imm = ir[8];
      rs = ir[7:6];
      adr = ir[7:0];
      k = {{8{adr[7]}}, adr};
      a = gpr[rd];
      b = imm ? k : gpr[rs];
      cin = sr_m & cpustep_pkg::F_C;
      case (op)
        cpustep_pkg::OP_LD: begin
          if (imm) gpr[rd] = k;
          else if (adr >= limit_m) begin
            sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_OOB);
            st = cpustep_pkg::ST_OOB; done = 1'b1;
          end else begin
            gpr[rd] = mem_img[adr + base_m];
            ticks = ticks + 32'd3;
          end
        end
        cpustep_pkg::OP_ST: begin
          if (adr >= limit_m) begin
            sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_OOB);
            st = cpustep_pkg::ST_OOB; done = 1'b1;
          end else begin
            mem_img[adr + base_m] = a;
            ticks = ticks + 32'd3;
          end
        end
        cpustep_pkg::OP_ADD, cpustep_pkg::OP_ADDC: begin
          t = {1'b0, a} + {1'b0, b} + ((op == cpustep_pkg::OP_ADDC) ? {1'b0, cin} : 17'd0);
          res = t[15:0];
          sr_m[0] = t[16];
          if (op == cpustep_pkg::OP_ADD) sr_m[4] = (a[15] ^ res[15]) & (b[15] ^ res[15]);
          gpr[rd] = res;
        end
        cpustep_pkg::OP_SUB, cpustep_pkg::OP_SUBC: begin
          t = {1'b0, b} + ((op == cpustep_pkg::OP_SUBC) ? {1'b0, cin} : 17'd0);
          res = a - t[15:0];
          sr_m[0] = {1'b0, a} < t;
          if (op == cpustep_pkg::OP_SUB) sr_m[4] = (a[15] ^ b[15]) & ~(b[15] ^ res[15]);
          gpr[rd] = res;
        end
        cpustep_pkg::OP_AND:   gpr[rd] = a & b;
        cpustep_pkg::OP_XOR:   gpr[rd] = a ^ b;
        cpustep_pkg::OP_COMPL: gpr[rd] = ~a;
        cpustep_pkg::OP_SHL: begin
          sr_m[0] = a[15]; gpr[rd] = {a[14:0], 1'b0};
        end
        cpustep_pkg::OP_SHLA: begin
          sr_m[0] = a[15]; gpr[rd] = {a[15], a[13:0], 1'b0};
        end
        cpustep_pkg::OP_SHR: begin
          sr_m[0] = a[0]; gpr[rd] = {1'b0, a[15:1]};
        end
        cpustep_pkg::OP_SHRA: begin
          sr_m[0] = a[0]; gpr[rd] = {a[15], a[15:1]};
        end
        cpustep_pkg::OP_COMP: begin
          sr_m = sr_m & 16'hffe1;
          if ($signed(a) < $signed(b)) sr_m = sr_m | cpustep_pkg::F_L;
          else if (a == b) sr_m = sr_m | cpustep_pkg::F_E;
          else sr_m = sr_m | cpustep_pkg::F_G;
        end
        cpustep_pkg::OP_GETST: gpr[rd] = sr_m;
        cpustep_pkg::OP_PUTST: sr_m = a;
        cpustep_pkg::OP_JUMP, cpustep_pkg::OP_JUMPL, cpustep_pkg::OP_JUMPE,
        cpustep_pkg::OP_JUMPG: begin
          cond = (op == cpustep_pkg::OP_JUMP) ||
                 (op == cpustep_pkg::OP_JUMPL && (sr_m & cpustep_pkg::F_L) != 0) ||
                 (op == cpustep_pkg::OP_JUMPE && (sr_m & cpustep_pkg::F_E) != 0) ||
                 (op == cpustep_pkg::OP_JUMPG && (sr_m & cpustep_pkg::F_G) != 0);
          if (cond) pc_m = {1'b0, adr} + {1'b0, base_m};
          if (adr >= limit_m) begin
            sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_OOB);
            st = cpustep_pkg::ST_OOB; done = 1'b1;
          end
        end
        cpustep_pkg::OP_CALL: begin
          if (adr >= limit_m) begin
            sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_OOB);
            st = cpustep_pkg::ST_OOB; done = 1'b1;
          end else if (int'(sp_m) < int'(floor_m) + cpustep_pkg::FRAME_WORDS) begin
            sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_OVER);
            st = cpustep_pkg::ST_OVER; done = 1'b1;
          end else begin
            sp_m = sp_m - 9'd1; mem_img[sp_m[7:0]] = {7'd0, pc_m};
            for (int j = 0; j < cpustep_pkg::NUM_REGS; j++) begin
              sp_m = sp_m - 9'd1; mem_img[sp_m[7:0]] = gpr[j];
            end
            sp_m = sp_m - 9'd1; mem_img[sp_m[7:0]] = sr_m;
            pc_m = {1'b0, adr} + {1'b0, base_m};
            ticks = ticks + 32'd3;
          end
        end
        cpustep_pkg::OP_RET: begin
          if (int'(sp_m) > cpustep_pkg::STACK_TOP - cpustep_pkg::FRAME_WORDS) begin
            sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_UNDER);
            st = cpustep_pkg::ST_UNDER; done = 1'b1;
          end else begin
            sr_m = mem_img[sp_m[7:0]]; sp_m = sp_m + 9'd1;
            for (int j = cpustep_pkg::NUM_REGS - 1; j >= 0; j--) begin
              gpr[j] = mem_img[sp_m[7:0]]; sp_m = sp_m + 9'd1;
            end
            pc_m = mem_img[sp_m[7:0]][8:0]; sp_m = sp_m + 9'd1;
            ticks = ticks + 32'd3;
          end
        end
        cpustep_pkg::OP_READ: begin
          gpr[rd] = rdval;
          sr_m = cpustep_pkg::set_io(sr_m, cpustep_pkg::RET_READ, rd);
          ioreg = rd; st = cpustep_pkg::ST_READ; done = 1'b1;
        end
        cpustep_pkg::OP_WRITE: begin
          oval = a;
          sr_m = cpustep_pkg::set_io(sr_m, cpustep_pkg::RET_WRITE, rd);
          ioreg = rd; st = cpustep_pkg::ST_WRITE; done = 1'b1;
        end
        cpustep_pkg::OP_HALT: begin
          sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_HALT);
          st = cpustep_pkg::ST_HALT; done = 1'b1;
        end
        cpustep_pkg::OP_NOOP: ;
        default: begin
          sr_m = cpustep_pkg::set_ret(sr_m, cpustep_pkg::RET_BAD);
          st = cpustep_pkg::ST_BAD; done = 1'b1;
        end
      endcase
      if (!done) exit_chk(st);
    end
  endtask

  task automatic predict_step(input step_req_t r);
    step_res_t e;
    cpustep_pkg::step_st_t st;
    if (r.req_type == cpustep_pkg::REQ_MEM_WR) begin
      mem_img[r.mem_addr] = r.mem_data;
    end else if (r.req_type == cpustep_pkg::REQ_START) begin
      pc_m = r.start_pc;
      sp_m = r.start_sp;
      deadline = ticks + slice_m;
    end else if (r.req_type == cpustep_pkg::REQ_EXEC) begin
      execute_insn(r.read_value, st, e.out_value, e.io_register);
      e.step_status = st;
      e.pc_now = pc_m;
      e.status_word = sr_m;
      e.clock_now = ticks;
      expected_steps.push_back(e);
    end
  endtask

  // driver
  int burst_left = 4, gap_left = 0;
  step_req_t cur;
  always @(posedge clk) begin
    took <= 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_step(cur);
      took <= 1'b1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0; in_ch.mem_addr = '0; in_ch.mem_data = '0;
    in_ch.start_pc = '0; in_ch.start_sp = '0; in_ch.read_value = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n && !(in_ch.valid && !took)) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        cur = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.req_type <= cur.req_type;
        in_ch.mem_addr <= cur.mem_addr;
        in_ch.mem_data <= cur.mem_data;
        in_ch.start_pc <= cur.start_pc;
        in_ch.start_sp <= cur.start_sp;
        in_ch.read_value <= cur.read_value;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0, mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 80);
    end
    mode_left--;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    step_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result status=%0d pc=%0d", $time,
                 out_ch.step_status, out_ch.pc_now);
        failures++;
      end else begin
        e = expected_steps.pop_front();
        if (out_ch.step_status !== e.step_status) begin
          $display("%0t: step_status exp %0d act %0d", $time, e.step_status,
                   out_ch.step_status);
          failures++;
        end
        if (out_ch.out_value !== e.out_value) begin
          $display("%0t: out_value exp %h act %h", $time, e.out_value, out_ch.out_value);
          failures++;
        end
        if (out_ch.io_register !== e.io_register) begin
          $display("%0t: io_register exp %0d act %0d", $time, e.io_register,
                   out_ch.io_register);
          failures++;
        end
        if (out_ch.pc_now !== e.pc_now) begin
          $display("%0t: pc_now exp %0d act %0d", $time, e.pc_now, out_ch.pc_now);
          failures++;
        end
        if (out_ch.status_word !== e.status_word) begin
          $display("%0t: status_word exp %h act %h", $time, e.status_word,
                   out_ch.status_word);
          failures++;
        end
        if (out_ch.clock_now !== e.clock_now) begin
          $display("%0t: clock_now exp %0d act %0d", $time, e.clock_now,
                   out_ch.clock_now);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 3000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      cpustep_pkg::REG_BASE:  base_m = val[7:0];
      cpustep_pkg::REG_LIMIT: limit_m = val[8:0];
      cpustep_pkg::REG_FLOOR: floor_m = val[8:0];
      default:                slice_m = val;
    endcase
  endtask

  task automatic configure(input logic [7:0] b, input logic [8:0] l,
                           input logic [8:0] f, input logic [31:0] s);
    apb_write(cpustep_pkg::REG_BASE, {24'd0, b});
    apb_write(cpustep_pkg::REG_LIMIT, {23'd0, l});
    apb_write(cpustep_pkg::REG_FLOOR, {23'd0, f});
    apb_write(cpustep_pkg::REG_SLICE, s);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0);
    while (in_ch.valid || expected_steps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic step_req_t mk_req(input logic [1:0] kind);
    step_req_t r;
    r.req_type = kind;
    r.mem_addr = 8'($urandom);
    r.mem_data = 16'($urandom);
    r.start_pc = 9'($urandom);
    r.start_sp = 9'($urandom);
    r.read_value = 16'($urandom);
    return r;
  endfunction

  function automatic logic [15:0] mk_insn();
    logic [4:0] op;
    logic [7:0] adr;
    int top;
    op = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                     : 5'($urandom_range(0, 25));
    top = (limit_m == 0) ? 0 : ((limit_m > 256) ? 255 : int'(limit_m) - 1);
    adr = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, top)) : 8'($urandom);
    return {op, 2'($urandom), 1'($urandom), adr};
  endfunction

  task automatic load_programs(input int n_items);
    step_req_t r;
    int cnt, len;
    logic [8:0] pc0;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_reqs.push_back(mk_req(2'($urandom)));
        cnt++;
      end else begin
        len = $urandom_range(3, 12);
        pc0 = {1'b0, base_m} + 9'($urandom_range(0, 40));
        for (int i = 0; i < len; i++) begin
          r = mk_req(cpustep_pkg::REQ_MEM_WR);
          r.mem_addr = pc0[7:0] + 8'(i);
          r.mem_data = mk_insn();
          pending_reqs.push_back(r);
        end
        r = mk_req(cpustep_pkg::REQ_START);
        r.start_pc = ($urandom_range(0, 15) == 0) ? 9'($urandom) : pc0;
        if ($urandom_range(0, 3) != 0) r.start_sp = 9'($urandom_range(200, 256));
        pending_reqs.push_back(r);
        for (int i = 0; i < len + 3; i++) pending_reqs.push_back(mk_req(cpustep_pkg::REQ_EXEC));
        cnt += 2 * len + 4;
      end
    end
  endtask

  initial begin
    step_req_t r;
    for (int i = 0; i < 256; i++) mem_img[i] = '0;
    for (int i = 0; i < 4; i++) gpr[i] = '0;
    pc_m = '0; sp_m = 9'd256; sr_m = '0; ticks = '0; deadline = '0;
    base_m = '0; limit_m = 9'd256; floor_m = '0; slice_m = 32'd15;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill word memory so that every later read is defined
    for (int i = 0; i < 256; i++) begin
      r = mk_req(cpustep_pkg::REQ_MEM_WR);
      r.mem_addr = 8'(i);
      pending_reqs.push_back(r);
    end
    // directed: slice never started, bad pc, extreme fields
    pending_reqs.push_back(mk_req(cpustep_pkg::REQ_EXEC));
    r = mk_req(cpustep_pkg::REQ_START); r.start_pc = 9'h1ff; r.start_sp = 9'h1ff;
    pending_reqs.push_back(r);
    pending_reqs.push_back(mk_req(cpustep_pkg::REQ_EXEC));
    r = mk_req(cpustep_pkg::REQ_MEM_WR); r.mem_addr = 8'd0;
    r.mem_data = {cpustep_pkg::OP_LD, 2'd1, 1'b1, 8'h7f};
    pending_reqs.push_back(r);
    r = mk_req(cpustep_pkg::REQ_MEM_WR); r.mem_addr = 8'd1;
    r.mem_data = {cpustep_pkg::OP_ADD, 2'd1, 1'b1, 8'h80};
    pending_reqs.push_back(r);
    r = mk_req(cpustep_pkg::REQ_MEM_WR); r.mem_addr = 8'd2;
    r.mem_data = {cpustep_pkg::OP_READ, 2'd3, 1'b0, 8'h00};
    pending_reqs.push_back(r);
    r = mk_req(cpustep_pkg::REQ_MEM_WR); r.mem_addr = 8'd3;
    r.mem_data = {cpustep_pkg::OP_WRITE, 2'd3, 1'b0, 8'h00};
    pending_reqs.push_back(r);
    r = mk_req(cpustep_pkg::REQ_MEM_WR); r.mem_addr = 8'd4;
    r.mem_data = {cpustep_pkg::OP_RET, 2'd0, 1'b0, 8'h00};
    pending_reqs.push_back(r);
    r = mk_req(cpustep_pkg::REQ_MEM_WR); r.mem_addr = 8'd5; r.mem_data = 16'hffff;
    pending_reqs.push_back(r);
    r = mk_req(cpustep_pkg::REQ_START); r.start_pc = 9'd0; r.start_sp = 9'd256;
    pending_reqs.push_back(r);
    for (int i = 0; i < 7; i++) begin
      r = mk_req(cpustep_pkg::REQ_EXEC);
      r.read_value = (i == 2) ? 16'sh8000 : 16'sh7fff;
      pending_reqs.push_back(r);
    end
    drain();

    configure(8'd0, 9'd256, 9'd0, 32'hffffffff);
    load_programs(110);
    drain();
    configure(8'd16, 9'd64, 9'd200, 32'd40);
    load_programs(100);
    drain();
    configure(8'd255, 9'd256, 9'd256, 32'd100);
    load_programs(100);
    drain();
    configure(8'($urandom), 9'($urandom_range(32, 256)), 9'($urandom_range(0, 256)),
              32'($urandom_range(1, 300)));
    load_programs(100);
    drain();
    configure(8'd0, 9'd0, 9'd0, 32'd0);
    load_programs(50);
    drain();
    configure(8'd3, 9'd200, 9'd100, 32'd1000);
    load_programs(100);
    drain();

    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/cpustep_pkg.sv
src/cpustep_ifs.sv
src/cpustep_ram.sv
src/cpustep_alu.sv
src/sixteen_bit_four_register_cpu_step_core.sv
sim/testbench.sv
